[design/bsle_pkg.sv]
package bsle_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int FOUND_W = 7;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_FIND       = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

[design/bounded_sequence_list_engine.sv]
// Timing: push rear and rejected requests strobe done in the cycle after the start beat;
// pop rear reads memory into a register, passes S_RDW and then registers done. Push front,
// insert, pop front, remove and find move or scan one stored element per cycle.
// Throughput: one beat at a time, busy high until done except for push rear and rejects;
// the memory does one read and one write per cycle. The receiver cannot stall results.
// Reset: rst_n clears the list to empty and the sequencer to idle; memory is not cleared.
module bounded_sequence_list_engine
    import bsle_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           operation,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  data_value,
    output logic                      done,
    output logic signed [DATA_W-1:0]  popped_value,
    output logic signed [FOUND_W-1:0] found_index,
    output logic [1:0]                status,
    output logic [COUNT_W-1:0]        element_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHR,
        S_SHL,
        S_SCAN,
        S_RDW
    } state_t;

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic [IDX_W-1:0]           lo_reg, lo_next;
    logic signed [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           cur_reg, cur_next;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic                       pend_reg, pend_next;
    logic [IDX_W-1:0]           paddr_reg, paddr_next;
    logic signed [DATA_W-1:0]   popped_reg, popped_next;
    logic [FOUND_W-1:0]         found_reg, found_next;
    status_t                    status_reg, status_next;
    logic                       done_reg, done_next;

    logic signed [DATA_W-1:0]   store_mem [DEPTH];
    logic signed [DATA_W-1:0]   rd_data_reg;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic signed [DATA_W-1:0]   wr_data;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;

    logic                       is_full;
    logic                       is_empty;
    logic                       pos_out;

    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign pos_out  = (CMP_W'(position) >= CMP_W'(cnt_reg));

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        paddr_next  = paddr_reg;
        popped_next = popped_reg;
        found_next  = found_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = paddr_reg;
        wr_data     = rd_data_reg;
        rd_en       = 1'b0;
        rd_addr     = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_t'(operation);
                    lo_next     = IDX_W'(position);
                    val_next    = data_value;
                    popped_next = '0;
                    found_next  = FOUND_NONE;
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    case (op_t'(operation))
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                cur_next   = IDX_W'(cnt_reg - 1'b1);
                                left_next  = cnt_reg;
                                state_next = S_SHR;
                            end
                        end
                        OP_PUSH_REAR:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = IDX_W'(cnt_reg);
                                wr_data  = data_value;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                cur_next   = '0;
                                left_next  = cnt_reg;
                                state_next = S_SHL;
                            end
                        end
                        OP_POP_REAR:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(cnt_reg - 1'b1);
                                state_next = S_RDW;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_out)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                cur_next   = IDX_W'(cnt_reg - 1'b1);
                                left_next  = cnt_reg - CNT_W'(position);
                                state_next = S_SHR;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else if (pos_out)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                cur_next   = IDX_W'(position) + 1'b1;
                                left_next  = cnt_reg - CNT_W'(position) - 1'b1;
                                state_next = S_SHL;
                            end
                        end
                        OP_FIND:
                        begin
                            if (is_empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                cur_next   = '0;
                                left_next  = cnt_reg;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SHR:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = paddr_reg + 1'b1;
                    wr_data = rd_data_reg;
                end
                if (left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = cur_reg;
                    cur_next   = cur_reg - 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = lo_reg;
                        wr_data    = val_reg;
                        cnt_next   = cnt_reg + 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_SHL:
            begin
                if (pend_reg)
                begin
                    if (op_reg == OP_POP_FRONT && paddr_reg == '0)
                    begin
                        popped_next = rd_data_reg;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = paddr_reg - 1'b1;
                        wr_data = rd_data_reg;
                    end
                end
                if (left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = cur_reg;
                    cur_next   = cur_reg + 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && rd_data_reg == val_reg)
                begin
                    found_next = FOUND_W'(paddr_reg);
                    pend_next  = 1'b0;
                    left_next  = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = cur_reg;
                    cur_next   = cur_reg + 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RDW:
            begin
                popped_next = rd_data_reg;
                cnt_next    = cnt_reg - 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            left_reg   <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= FOUND_NONE;
            popped_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            popped_reg <= popped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        lo_reg    <= lo_next;
        val_reg   <= val_next;
        cur_reg   <= cur_next;
        paddr_reg <= paddr_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign popped_value  = popped_reg;
    assign found_index   = found_reg;
    assign status        = status_reg;
    assign element_count = COUNT_W'(cnt_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("element count exceeds the list depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> (cnt_reg == $past(cnt_reg) + 1'b1 ||
                               cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("element count changed by more than one");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_FULL |-> cnt_reg == CNT_W'(DEPTH))
        else $error("full status reported on a list that is not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_EMPTY |-> cnt_reg == '0 && popped_reg == '0)
        else $error("empty status reported on a list that holds elements");

    a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> left_reg == '0 && !pend_reg)
        else $error("sequencer idle with element moves outstanding");

endmodule
